// ----- rtl/fixed_point_vertex_transform_defines.svh -----
// assertion macros for the vertex transform
`ifndef FIXED_POINT_VERTEX_TRANSFORM_DEFINES_SVH
`define FIXED_POINT_VERTEX_TRANSFORM_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define FPVT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("fpvt assertion failed");

// implication checked on the following clock edge
`define FPVT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fpvt assertion failed");

`endif

// ----- rtl/fpvt_pkg.sv -----
// shared constants and types for the vertex transform
package fpvt_pkg;

    localparam int WORD_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int MAT_DEPTH = 16;
    localparam int IDX_W     = 4;
    localparam int QUOT_W    = WORD_W + FRAC_BITS;
    localparam int DIV_RADIX_BITS = 2;
    localparam int DIV_STEPS = QUOT_W / DIV_RADIX_BITS;

    typedef logic [WORD_W-1:0] t_word;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_XFORM = 2'd1,
        OP_PROJ  = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

endpackage

// ----- rtl/fpvt_lane.sv -----
// one row lane: four products then their wrapped sum
module fpvt_lane #(
    parameter int SW = 24
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [SW-1:0]       i_row [4],
    input  fpvt_pkg::t_word            i_pt  [4],
    output fpvt_pkg::t_word            o_sum
);

    fpvt_pkg::t_word r_prod [4];
    fpvt_pkg::t_word n_prod [4];
    fpvt_pkg::t_word r_sum;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            n_prod[c] = fpvt_pkg::t_word'(fpvt_pkg::WORD_W'(i_row[c])) * i_pt[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
            r_sum  <= r_prod[0] + r_prod[1] + r_prod[2] + r_prod[3];
        end
    end

    assign o_sum = r_sum;

endmodule

// ----- rtl/fpvt_div.sv -----
// pipelined signed 16.16 divider, two quotient bits per stage
module fpvt_div (
    input  logic            i_clk,
    input  logic            i_en,
    input  fpvt_pkg::t_word i_num,
    input  fpvt_pkg::t_word i_den,
    output fpvt_pkg::t_word o_quot
);

    localparam int W  = fpvt_pkg::WORD_W;
    localparam int QW = fpvt_pkg::QUOT_W;
    localparam int NS = fpvt_pkg::DIV_STEPS;
    localparam int RB = fpvt_pkg::DIV_RADIX_BITS;

    logic [W:0]    r_rem [NS+1];
    logic [QW-1:0] r_dq  [NS+1];
    logic [W-1:0]  r_d   [NS+1];
    logic          r_neg [NS+1];
    fpvt_pkg::t_word r_quot;

    logic [W-1:0]  n_anum;
    logic [W-1:0]  n_aden;
    logic [QW-1:0] n_qneg;

    always_comb begin
        n_anum = i_num[W-1] ? (~i_num + 1'b1) : i_num;
        n_aden = i_den[W-1] ? (~i_den + 1'b1) : i_den;
        n_qneg = ~r_dq[NS] + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_dq[0]  <= {n_anum, {fpvt_pkg::FRAC_BITS{1'b0}}};
            r_d[0]   <= n_aden;
            r_neg[0] <= i_num[W-1] ^ i_den[W-1];
            r_quot   <= r_neg[NS] ? n_qneg[W-1:0] : r_dq[NS][W-1:0];
        end
    end

    for (genvar s = 0; s < NS; s++) begin : g_step
        logic [W:0]    n_rem [RB+1];
        logic [QW-1:0] n_dq  [RB+1];
        logic [W:0]    n_sh  [RB];

        always_comb begin
            n_rem[0] = r_rem[s];
            n_dq[0]  = r_dq[s];
            for (int b = 0; b < RB; b++) begin
                n_sh[b] = {n_rem[b][W-1:0], n_dq[b][QW-1]};
                if (n_sh[b] >= {1'b0, r_d[s]}) begin
                    n_rem[b+1] = n_sh[b] - {1'b0, r_d[s]};
                    n_dq[b+1]  = {n_dq[b][QW-2:0], 1'b1};
                end else begin
                    n_rem[b+1] = n_sh[b];
                    n_dq[b+1]  = {n_dq[b][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= n_rem[RB];
                r_dq[s+1]  <= n_dq[RB];
                r_d[s+1]   <= r_d[s];
                r_neg[s+1] <= r_neg[s];
            end
        end
    end

    assign o_quot = r_quot;

endmodule

// ----- rtl/fixed_point_vertex_transform.sv -----
// fixed-point 4x4 vertex transform with optional perspective divide
//
//  channel | valid       | ready        | fields
//  in      | i_in_valid  | o_in_ready   | i_op, i_entry_index, i_entry_value, i_point_x..w
//  out     | o_out_valid | i_out_ready  | o_out_x, o_out_y, o_out_z, o_out_w, o_divide_by_zero
//
// one word per cycle in and out while the output word is taken; a transform result passes
// through 28 register stages: two in the row lanes, then 26 in the divider pipeline
// (24 radix-4 steps)
// a matrix write takes effect for the next accepted word and gives no result
// the whole pipeline holds when the output word is not taken; reset clears the matrix
`include "fixed_point_vertex_transform_defines.svh"

module fixed_point_vertex_transform #(
    parameter int PRE_SHIFT = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_op,
    input  logic [3:0]               i_entry_index,
    input  logic signed [31:0]       i_entry_value,
    input  logic signed [31:0]       i_point_x,
    input  logic signed [31:0]       i_point_y,
    input  logic signed [31:0]       i_point_z,
    input  logic signed [31:0]       i_point_w,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [31:0]       o_out_x,
    output logic signed [31:0]       o_out_y,
    output logic signed [31:0]       o_out_z,
    output logic signed [31:0]       o_out_w,
    output logic                     o_divide_by_zero
);

    localparam int SW       = fpvt_pkg::WORD_W - PRE_SHIFT;
    localparam int PT_SHIFT = fpvt_pkg::FRAC_BITS - PRE_SHIFT;
    localparam int DIV_LAT  = fpvt_pkg::DIV_STEPS + 2;
    localparam int NSTG     = DIV_LAT + 2;

    logic signed [SW-1:0] r_store [fpvt_pkg::MAT_DEPTH];
    logic                 r_vld   [NSTG];
    logic                 r_proj  [NSTG];
    fpvt_pkg::t_word      r_sx [DIV_LAT];
    fpvt_pkg::t_word      r_sy [DIV_LAT];
    fpvt_pkg::t_word      r_sz [DIV_LAT];
    fpvt_pkg::t_word      r_sw [DIV_LAT];
    logic                 r_zero [DIV_LAT];

    logic            en;
    logic            acc;
    fpvt_pkg::t_op   op;
    fpvt_pkg::t_word pt   [4];
    fpvt_pkg::t_word sums [4];
    fpvt_pkg::t_word qx, qy;

    assign op  = fpvt_pkg::t_op'(i_op);
    assign en  = !r_vld[NSTG-1] || i_out_ready;
    assign acc = i_in_valid && en;
    assign o_in_ready = en;

    assign pt[0] = fpvt_pkg::t_word'(i_point_x >>> PT_SHIFT);
    assign pt[1] = fpvt_pkg::t_word'(i_point_y >>> PT_SHIFT);
    assign pt[2] = fpvt_pkg::t_word'(i_point_z >>> PT_SHIFT);
    assign pt[3] = fpvt_pkg::t_word'(i_point_w >>> PT_SHIFT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < fpvt_pkg::MAT_DEPTH; i++) begin
                r_store[i] <= '0;
            end
        end else if (acc && op == fpvt_pkg::OP_WRITE) begin
            r_store[i_entry_index] <= SW'(i_entry_value >>> PRE_SHIFT);
        end
    end

    for (genvar r = 0; r < 4; r++) begin : g_lane
        logic signed [SW-1:0] row [4];
        for (genvar c = 0; c < 4; c++) begin : g_col
            assign row[c] = r_store[r*4 + c];
        end
        fpvt_lane #(.SW(SW)) u_lane (
            .i_clk (i_clk),
            .i_en  (en),
            .i_row (row),
            .i_pt  (pt),
            .o_sum (sums[r])
        );
    end

    fpvt_div u_div_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (sums[0]),
        .i_den  (sums[3]),
        .o_quot (qx)
    );

    fpvt_div u_div_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_num  (sums[1]),
        .i_den  (sums[3]),
        .o_quot (qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= acc && (op == fpvt_pkg::OP_XFORM || op == fpvt_pkg::OP_PROJ);
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // side data rides along with the divider stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_proj[0] <= (op == fpvt_pkg::OP_PROJ);
            for (int k = 1; k < NSTG; k++) begin
                r_proj[k] <= r_proj[k-1];
            end
            r_sx[0]   <= sums[0];
            r_sy[0]   <= sums[1];
            r_sz[0]   <= sums[2];
            r_sw[0]   <= sums[3];
            r_zero[0] <= (sums[3] == '0);
            for (int j = 1; j < DIV_LAT; j++) begin
                r_sx[j]   <= r_sx[j-1];
                r_sy[j]   <= r_sy[j-1];
                r_sz[j]   <= r_sz[j-1];
                r_sw[j]   <= r_sw[j-1];
                r_zero[j] <= r_zero[j-1];
            end
        end
    end

    // merge: pick lane sums or quotients
    always_comb begin
        o_out_valid = r_vld[NSTG-1];
        o_out_w     = r_sw[DIV_LAT-1];
        if (r_proj[NSTG-1]) begin
            o_divide_by_zero = r_zero[DIV_LAT-1];
            o_out_x = r_zero[DIV_LAT-1] ? '0 : qx;
            o_out_y = r_zero[DIV_LAT-1] ? '0 : qy;
            o_out_z = '0;
        end else begin
            o_divide_by_zero = 1'b0;
            o_out_x = r_sx[DIV_LAT-1];
            o_out_y = r_sy[DIV_LAT-1];
            o_out_z = r_sz[DIV_LAT-1];
        end
    end

    `FPVT_ASSERT(a_zero_only_proj, !(o_out_valid && o_divide_by_zero) || r_proj[NSTG-1])
    `FPVT_ASSERT(a_proj_z_zero, !(o_out_valid && r_proj[NSTG-1]) || o_out_z == '0)
    `FPVT_ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready, o_out_valid)
    `FPVT_ASSERT_NEXT(a_store_write, acc && op == fpvt_pkg::OP_WRITE,
        r_store[$past(i_entry_index)] == SW'($past(i_entry_value) >>> PRE_SHIFT))

endmodule

// ----- tb/sv/vertex_checker.sv -----
// checker that predicts and compares vertex transform output words
`timescale 1ns / 1ps

module vertex_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic [1:0]         i_op,
    input  logic [3:0]         i_entry_index,
    input  logic signed [31:0] i_entry_value,
    input  logic signed [31:0] i_point_x,
    input  logic signed [31:0] i_point_y,
    input  logic signed [31:0] i_point_z,
    input  logic signed [31:0] i_point_w,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic signed [31:0] i_out_x,
    input  logic signed [31:0] i_out_y,
    input  logic signed [31:0] i_out_z,
    input  logic signed [31:0] i_out_w,
    input  logic               i_divide_by_zero,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] w;
        logic        dz;
    } t_vertex;

    logic [31:0] matrix_words [16];
    t_vertex     expected_vertices [$];

    assign o_pending = expected_vertices.size();

    function automatic logic [31:0] row_sum(int row, logic [31:0] pt [4]);
        logic [31:0] acc;
        acc = '0;
        for (int c = 0; c < 4; c++) acc += matrix_words[row*4 + c] * pt[c];
        return acc;
    endfunction

    function automatic logic [31:0] fixed_quotient(logic [31:0] a, logic [31:0] b);
        logic signed [63:0] num;
        logic signed [63:0] q;
        num = $signed(a) * 64'sd65536;
        q   = num / $signed({{32{b[31]}}, b});
        return q[31:0];
    endfunction

    function automatic t_vertex transform_point(logic [1:0] op, logic [31:0] px,
        logic [31:0] py, logic [31:0] pz, logic [31:0] pw);
        logic [31:0] pt [4];
        t_vertex v;
        pt[0] = $signed(px) >>> (fpvt_pkg::FRAC_BITS - 8);
        pt[1] = $signed(py) >>> (fpvt_pkg::FRAC_BITS - 8);
        pt[2] = $signed(pz) >>> (fpvt_pkg::FRAC_BITS - 8);
        pt[3] = $signed(pw) >>> (fpvt_pkg::FRAC_BITS - 8);
        v.w  = row_sum(3, pt);
        v.dz = 1'b0;
        if (op == fpvt_pkg::OP_XFORM) begin
            v.x = row_sum(0, pt);
            v.y = row_sum(1, pt);
            v.z = row_sum(2, pt);
        end else if (v.w == 0) begin
            v.x  = '0;
            v.y  = '0;
            v.z  = '0;
            v.dz = 1'b1;
        end else begin
            v.x = fixed_quotient(row_sum(0, pt), v.w);
            v.y = fixed_quotient(row_sum(1, pt), v.w);
            v.z = '0;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        foreach (matrix_words[i]) matrix_words[i] = '0;
    end

    always @(posedge i_clk) begin
        t_vertex want;
        if (!i_rst_n) begin
            foreach (matrix_words[i]) matrix_words[i] = '0;
            expected_vertices.delete();
        end else begin
            // output side first: a word accepted now cannot appear in the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_vertices.size() == 0) begin
                    $display("unexpected output word at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    want = expected_vertices.pop_front();
                    if (i_out_x !== want.x) report_mismatch("x", i_out_x, want.x);
                    if (i_out_y !== want.y) report_mismatch("y", i_out_y, want.y);
                    if (i_out_z !== want.z) report_mismatch("z", i_out_z, want.z);
                    if (i_out_w !== want.w) report_mismatch("w", i_out_w, want.w);
                    if (i_divide_by_zero !== want.dz)
                        report_mismatch("divide_by_zero", {31'b0, i_divide_by_zero},
                            {31'b0, want.dz});
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_op == fpvt_pkg::OP_WRITE)
                    matrix_words[i_entry_index] = i_entry_value >>> 8;
                else if (i_op == fpvt_pkg::OP_XFORM || i_op == fpvt_pkg::OP_PROJ)
                    expected_vertices.push_back(transform_point(i_op, i_point_x,
                        i_point_y, i_point_z, i_point_w));
            end
        end
    end

endmodule

// ----- tb/sv/tb_top.sv -----
// stimulus and verdict for the vertex transform testbench
`timescale 1ns / 1ps

module tb_top;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_op;
    logic [3:0]         i_entry_index;
    logic signed [31:0] i_entry_value;
    logic signed [31:0] i_point_x;
    logic signed [31:0] i_point_y;
    logic signed [31:0] i_point_z;
    logic signed [31:0] i_point_w;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [31:0] o_out_z;
    logic signed [31:0] o_out_w;
    logic               o_divide_by_zero;
    int                 fail_count;
    int                 pending;
    logic               stall_enable;

    fixed_point_vertex_transform dut (.*);

    vertex_checker checker_inst (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_ready(o_in_ready), .i_op, .i_entry_index,
        .i_entry_value, .i_point_x, .i_point_y, .i_point_z, .i_point_w,
        .i_out_valid(o_out_valid), .i_out_ready, .i_out_x(o_out_x), .i_out_y(o_out_y),
        .i_out_z(o_out_z), .i_out_w(o_out_w), .i_divide_by_zero(o_divide_by_zero),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int gap_length();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    function automatic logic [31:0] random_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
            3: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // receiver side: random stalls, with stretches of none
    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_ready <= 1'b0;
        else if (!stall_enable) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0
                            : ($urandom_range(0, 3) != 0);
    end

    task automatic send_word(logic [1:0] op, logic [3:0] idx, logic [31:0] val,
        logic [31:0] px, logic [31:0] py, logic [31:0] pz, logic [31:0] pw);
        int gap;
        gap = stall_enable ? gap_length() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_entry_index <= idx;
        i_entry_value <= val;
        i_point_x     <= px;
        i_point_y     <= py;
        i_point_z     <= pz;
        i_point_w     <= pw;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_matrix(logic [31:0] m [16]);
        for (int i = 0; i < 16; i++)
            send_word(fpvt_pkg::OP_WRITE, 4'(i), m[i], random_word(), random_word(), 0, 0);
    endtask

    initial begin
        logic [31:0] m [16];
        logic [31:0] w;
        int wait_cycles;
        i_rst_n = 1'b0; i_in_valid = 1'b0; i_op = fpvt_pkg::OP_WRITE; i_entry_index = '0;
        i_entry_value = '0; i_point_x = '0; i_point_y = '0; i_point_z = '0;
        i_point_w = '0; stall_enable = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // cleared matrix, ignored op, then identity and extremes
        send_word(fpvt_pkg::OP_XFORM, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 1, 32'hffff_ffff);
        send_word(fpvt_pkg::OP_PROJ, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, 32'h0001_0000);
        send_word(fpvt_pkg::OP_NONE, 4'hf, 32'h8000_0000, 1, 1, 1, 1);
        for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
        write_matrix(m);
        send_word(fpvt_pkg::OP_XFORM, 0, 0, 32'h0003_0000, 32'hfffe_0000, 32'h0000_8000,
                  32'h0001_0000);
        send_word(fpvt_pkg::OP_PROJ, 0, 0, 32'h0004_0000, 32'hfff8_0000, 0, 32'h0002_0000);
        send_word(fpvt_pkg::OP_PROJ, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 0, 32'h0000_0100);
        send_word(fpvt_pkg::OP_PROJ, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 0);
        send_word(fpvt_pkg::OP_WRITE, 4'hf, 32'h7fff_ffff, 0, 0, 0, 0);
        send_word(fpvt_pkg::OP_WRITE, 4'h0, 32'h8000_0000, 0, 0, 0, 0);
        send_word(fpvt_pkg::OP_XFORM, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                  32'h7fff_ffff);
        send_word(fpvt_pkg::OP_PROJ, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff);

        stall_enable = 1'b1;
        for (int phase = 0; phase < 10; phase++) begin
            for (int i = 0; i < 16; i++)
                m[i] = ($urandom_range(0, 3) == 0) ? random_word()
                       : ($urandom_range(0, 1) ? $urandom_range(0, 32'h0003_0000)
                          : -$urandom_range(0, 32'h0003_0000));
            write_matrix(m);
            for (int k = 0; k < 48; k++) begin
                w = ($urandom_range(0, 9) == 0) ? 32'h0 : random_word();
                case ($urandom_range(0, 9))
                    0: send_word(fpvt_pkg::OP_WRITE, 4'($urandom), random_word(), 0, 0, 0, 0);
                    1: send_word(fpvt_pkg::OP_NONE, 4'($urandom), $urandom, $urandom, 0, 0, 0);
                    2, 3, 4: send_word(fpvt_pkg::OP_XFORM, 4'($urandom), $urandom,
                                       random_word(), random_word(), random_word(), w);
                    default: send_word(fpvt_pkg::OP_PROJ, 4'($urandom), $urandom,
                                       random_word(), random_word(), random_word(), w);
                endcase
            end
            if (phase == 5) stall_enable = 1'b0;
            if (phase == 7) stall_enable = 1'b1;
        end
        i_in_valid <= 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (60) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("fixed_point_vertex_transform verification clean");
        else
            $display("fixed_point_vertex_transform verification failed");
        $finish;
    end

    initial begin
        #5ms;
        $display("fixed_point_vertex_transform verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/fpvt_pkg.sv
rtl/fpvt_lane.sv
rtl/fpvt_div.sv
rtl/fixed_point_vertex_transform.sv
tb/sv/vertex_checker.sv
tb/sv/tb_top.sv
